// ===== rtl/core/fhpv_pkg.sv =====
// Shared types, constants and lookup functions for the frame header/payload validator.
package fhpv_pkg;

    localparam int unsigned ACTION_COUNT    = 5;
    localparam int unsigned HEADER_BYTES    = 3;
    localparam int unsigned MAX_FRAME_BYTES = 256;
    localparam int unsigned ENTRY_COUNT     = 5;

    localparam int unsigned LIMITS_W = 8 * ENTRY_COUNT;
    localparam int unsigned COUNTS_W = 4 * ENTRY_COUNT;
    localparam int unsigned POS_W    = 9;
    localparam int unsigned APB_DW   = 64;
    localparam int unsigned APB_AW   = 4;

    localparam logic [7:0] CHAR_LOW  = 8'h21;  // '!'
    localparam logic [7:0] CHAR_HIGH = 8'h7E;  // '~'
    localparam logic [7:0] CHAR_NUL  = 8'h00;

    localparam logic [POS_W-1:0] HDR_POS  = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] MAX_POS  = POS_W'(MAX_FRAME_BYTES);
    localparam logic [7:0]       ACT_LIM  = 8'(ACTION_COUNT);

    // Register indexes (byte address = 8 * index)
    localparam logic REG_OPTION_LIMITS = 1'b0;
    localparam logic REG_FIELD_COUNTS  = 1'b1;

    typedef enum logic [2:0] {
        ST_VALID      = 3'd0,
        ST_BAD_ACTION = 3'd1,
        ST_BAD_OPTION = 3'd2,
        ST_BAD_SIZE   = 3'd3,
        ST_BAD_DATA   = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [3:0] field_number;
        logic       field_end;
        logic       verdict_valid;
        logic [2:0] status;
        logic [2:0] action_code;
        logic [7:0] option_code;
        logic [8:0] frame_length;
    } t_out;

    typedef struct packed {
        logic [LIMITS_W-1:0] option_limits;
        logic [COUNTS_W-1:0] field_counts;
    } t_cfg;

    function automatic logic [7:0] limit_of(input logic [LIMITS_W-1:0] lim,
                                            input logic [2:0] act);
        logic [7:0] res;
        res = 8'd0;
        for (int k = 0; k < ENTRY_COUNT; k++) begin
            if (act == 3'(k)) begin
                res = lim[8*k +: 8];
            end
        end
        return res;
    endfunction

    function automatic logic [3:0] count_of(input logic [COUNTS_W-1:0] cnt,
                                            input logic [2:0] act);
        logic [3:0] res;
        res = 4'd0;
        for (int k = 0; k < ENTRY_COUNT; k++) begin
            if (act == 3'(k)) begin
                res = cnt[4*k +: 4];
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/fhpv_cfg_regs.sv =====
// APB configuration registers: option limits and field counts.
module fhpv_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fhpv_pkg::APB_AW-1:0] paddr,
    input  logic [fhpv_pkg::APB_DW-1:0] pwdata,
    output logic [fhpv_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output fhpv_pkg::t_cfg              o_cfg
);
    import fhpv_pkg::*;

    logic [LIMITS_W-1:0] r_option_limits;
    logic [COUNTS_W-1:0] r_field_counts;
    logic                wr_en;
    logic                reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_option_limits <= '0;
            r_field_counts  <= '0;
        end else if (wr_en) begin
            if (reg_sel == REG_OPTION_LIMITS) begin
                r_option_limits <= pwdata[LIMITS_W-1:0];
            end else begin
                r_field_counts <= pwdata[COUNTS_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_sel == REG_OPTION_LIMITS) begin
            prdata = APB_DW'(r_option_limits);
        end else begin
            prdata = APB_DW'(r_field_counts);
        end
    end

    assign o_cfg.option_limits = r_option_limits;
    assign o_cfg.field_counts  = r_field_counts;

endmodule

// ===== rtl/core/fhpv_parser.sv =====
// Frame parse state and the per-byte check logic.
module fhpv_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_advance,
    input  fhpv_pkg::t_in  i_item,
    input  fhpv_pkg::t_cfg i_cfg,
    output fhpv_pkg::t_out o_result
);
    import fhpv_pkg::*;

    logic [POS_W-1:0] r_pos,      n_pos;
    logic [2:0]       r_action,   n_action;
    logic [7:0]       r_option,   n_option;
    logic [7:0]       r_size,     n_size;
    logic [3:0]       r_fields,   n_fields;
    logic             r_finished, n_finished;

    logic [7:0]       b;
    logic [7:0]       lim;
    logic [3:0]       cnt;
    logic [3:0]       fields_inc;
    logic [POS_W-1:0] size_end;
    t_out             res;

    assign b          = i_item.rx_byte;
    assign lim        = limit_of(i_cfg.option_limits, r_action);
    assign cnt        = count_of(i_cfg.field_counts, r_action);
    assign fields_inc = r_fields + 4'd1;
    assign size_end   = POS_W'(r_size) + HDR_POS;

    always_comb begin
        n_pos      = r_pos;
        n_action   = r_action;
        n_option   = r_option;
        n_size     = r_size;
        n_fields   = r_fields;
        n_finished = r_finished;
        res        = '0;

        if (i_item.frame_start) begin
            n_option = 8'd0;
            n_size   = 8'd0;
            n_fields = 4'd0;
            if (b >= ACT_LIM) begin
                n_action          = 3'd0;
                res.verdict_valid = 1'b1;
                res.status        = ST_BAD_ACTION;
                n_finished        = 1'b1;
            end else begin
                n_action   = b[2:0];
                n_pos      = POS_W'(1);
                n_finished = 1'b0;
            end
        end else if (!r_finished) begin
            if (r_pos == POS_W'(1)) begin
                if (b > lim) begin
                    res.verdict_valid = 1'b1;
                    res.status        = ST_BAD_OPTION;
                    n_finished        = 1'b1;
                end else begin
                    n_option = b;
                    n_pos    = POS_W'(2);
                end
            end else if (r_pos == POS_W'(2)) begin
                n_size = b;
                if (cnt == 4'd0) begin
                    // no payload fields: verdict comes with the size byte
                    res.verdict_valid = 1'b1;
                    n_finished        = 1'b1;
                    if (b != 8'd0) begin
                        res.status = ST_BAD_SIZE;
                    end else begin
                        res.status       = ST_VALID;
                        res.frame_length = HDR_POS;
                    end
                end else begin
                    n_fields = 4'd0;
                    n_pos    = HDR_POS;
                end
            end else begin
                if (r_pos >= size_end || r_pos >= MAX_POS) begin
                    res.verdict_valid = 1'b1;
                    res.status        = ST_BAD_SIZE;
                    n_finished        = 1'b1;
                end else if (b != CHAR_NUL && (b < CHAR_LOW || b > CHAR_HIGH)) begin
                    res.verdict_valid = 1'b1;
                    res.status        = ST_BAD_DATA;
                    n_finished        = 1'b1;
                end else begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = b;
                    res.field_number  = r_fields;
                    n_pos             = r_pos + POS_W'(1);
                    if (b == CHAR_NUL) begin
                        res.field_end = 1'b1;
                        n_fields      = fields_inc;
                        if (fields_inc == cnt) begin
                            res.verdict_valid = 1'b1;
                            res.status        = ST_VALID;
                            res.frame_length  = size_end;
                            n_finished        = 1'b1;
                        end
                    end
                end
            end
        end

        res.action_code = n_action;
        res.option_code = n_option;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_action   <= '0;
            r_option   <= '0;
            r_size     <= '0;
            r_fields   <= '0;
            r_finished <= 1'b1;
        end else if (i_advance) begin
            r_pos      <= n_pos;
            r_action   <= n_action;
            r_option   <= n_option;
            r_size     <= n_size;
            r_fields   <= n_fields;
            r_finished <= n_finished;
        end
    end

    assign o_result = res;

endmodule

// ===== rtl/core/frame_header_payload_validator_unit.sv =====
// Top level of the frame header/payload validator: input register, checker, result register.
//
// Checks a received frame one byte per transaction. A byte with frame_start set opens a
// frame as the action byte; then the option byte (checked against the action's limit in
// option_limits), the payload size byte, and the payload as the action's number of
// NUL-terminated printable-ASCII fields (count from field_counts). Every input transaction
// yields exactly one output transaction carrying the passed payload byte (with its field
// index and end-of-field flag), and once per frame the final status. Bytes with no open
// frame give a result with no payload or verdict flag, only the held action and option
// codes. Throughput is one transaction per cycle while the output side does not stall.
// Each accepted transaction goes from the input register through the combinational check
// logic to the result register. The input side stalls only while both registers are full
// and the output side is stalling. Configuration is to be written over the APB port
// (option_limits at 0x0, field_counts at 0x8, 64-bit data) only while idle; not enforced.
module frame_header_payload_validator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  fhpv_pkg::t_in               i_data,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output fhpv_pkg::t_out              o_data,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fhpv_pkg::APB_AW-1:0] paddr,
    input  logic [fhpv_pkg::APB_DW-1:0] pwdata,
    output logic [fhpv_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import fhpv_pkg::*;

    t_cfg cfg;
    t_in  r_in_data;
    logic r_in_valid;
    t_out r_out_data;
    logic r_out_valid;
    t_out result;
    logic out_free;
    logic advance;
    logic in_take;

    fhpv_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // result register can take a new value when empty or being drained
    assign out_free = !r_out_valid || !i_stall;
    // held byte moves through the checker into the result register; state updates here
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    fhpv_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_data),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_data;
        end
        if (advance) begin
            r_out_data <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the frame header/payload validator unit.
`timescale 1ns / 100ps

module testbench;
    import fhpv_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int REPORT_CAP  = 100;   // mismatch lines printed before going quiet

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // input channel
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_data = '0;

    // result channel
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;

    // configuration port
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    frame_header_payload_validator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predicted copy of the checker: configuration and per-frame state.
    // Reset values match the block's state after reset.
    // ------------------------------------------------------------------
    logic [LIMITS_W-1:0] cfg_limits = '0;
    logic [COUNTS_W-1:0] cfg_counts = '0;
    logic [8:0]          fr_pos = '0;
    logic [2:0]          fr_act = '0;
    logic [7:0]          fr_opt = '0;
    logic [7:0]          fr_size = '0;
    logic [3:0]          fr_fields = '0;
    logic                fr_closed = 1'b1;   // no frame open until a start byte

    t_in  pending_bytes[$];   // frame bytes not yet offered to the block
    t_out results_due[$];     // predicted results, oldest first
    t_out next_result;

    bit in_taken = 1'b0;      // last rising edge accepted an input transaction
    bit idle_on = 1'b1;       // random idling and stalling allowed
    int in_gap = 0;
    int out_gap = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int payload_seen = 0;
    int long_frames = 0;
    int settings_used = 0;
    int verdict_seen[5];

    function automatic logic [7:0] action_limit(logic [2:0] act);
        return (act < ENTRY_COUNT) ? cfg_limits[8*act +: 8] : 8'd0;
    endfunction

    function automatic logic [3:0] action_fields(logic [2:0] act);
        return (act < ENTRY_COUNT) ? cfg_counts[4*act +: 4] : 4'd0;
    endfunction

    // Advance the predicted checker by one frame byte; returns its result.
    function automatic t_out frame_step(t_in it);
        t_out       r;
        logic [8:0] ppos;
        r = '0;
        if (it.frame_start) begin
            // a start always drops any open frame silently; a valid action opens a new one
            fr_opt = '0;
            fr_size = '0;
            fr_fields = '0;
            if (it.rx_byte >= ACTION_COUNT) begin
                fr_act = '0;
                r.verdict_valid = 1'b1;
                r.status = ST_BAD_ACTION;
                fr_closed = 1'b1;
            end else begin
                fr_act = it.rx_byte[2:0];
                fr_pos = 9'd1;
                fr_closed = 1'b0;
            end
        end else if (!fr_closed) begin
            if (fr_pos == 9'd1) begin
                if (it.rx_byte > action_limit(fr_act)) begin
                    r.verdict_valid = 1'b1;
                    r.status = ST_BAD_OPTION;
                    fr_closed = 1'b1;
                end else begin
                    fr_opt = it.rx_byte;
                    fr_pos = 9'd2;
                end
            end else if (fr_pos == 9'd2) begin
                fr_size = it.rx_byte;
                if (action_fields(fr_act) == 4'd0) begin
                    // no fields: verdict right on the size byte
                    r.verdict_valid = 1'b1;
                    fr_closed = 1'b1;
                    if (it.rx_byte != 8'd0) begin
                        r.status = ST_BAD_SIZE;
                    end else begin
                        r.status = ST_VALID;
                        r.frame_length = 9'(HEADER_BYTES);
                    end
                end else begin
                    fr_fields = '0;
                    fr_pos = 9'(HEADER_BYTES);
                end
            end else begin
                ppos = fr_pos - 9'(HEADER_BYTES);
                if (ppos >= fr_size || fr_pos >= MAX_FRAME_BYTES) begin
                    r.verdict_valid = 1'b1;
                    r.status = ST_BAD_SIZE;
                    fr_closed = 1'b1;
                end else if (it.rx_byte != CHAR_NUL &&
                             (it.rx_byte < CHAR_LOW || it.rx_byte > CHAR_HIGH)) begin
                    r.verdict_valid = 1'b1;
                    r.status = ST_BAD_DATA;
                    fr_closed = 1'b1;
                end else begin
                    r.payload_valid = 1'b1;
                    r.payload_byte = it.rx_byte;
                    r.field_number = fr_fields;
                    fr_pos = fr_pos + 9'd1;
                    if (it.rx_byte == CHAR_NUL) begin
                        r.field_end = 1'b1;
                        fr_fields = fr_fields + 4'd1;
                        // NUL of the last field carries the valid verdict too
                        if (fr_fields == action_fields(fr_act)) begin
                            r.verdict_valid = 1'b1;
                            r.status = ST_VALID;
                            r.frame_length = 9'(HEADER_BYTES) + 9'(fr_size);
                            fr_closed = 1'b1;
                        end
                    end
                end
            end
        end
        r.action_code = fr_act;
        r.option_code = fr_opt;
        return r;
    endfunction

    function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            if (mismatches < REPORT_CAP)
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic void queue_byte(logic [7:0] b, logic s);
        t_in it;
        it.rx_byte = b;
        it.frame_start = s;
        pending_bytes.push_back(it);
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(CHAR_LOW, CHAR_HIGH));
    endfunction

    // One random frame (or stray bytes) against the current register setting.
    // Well-formed frames with random content, mixed with broken ones.
    function automatic void add_frame();
        int         pick, mut, act, lim, n, sz, len;
        logic [7:0] body[$];
        logic [7:0] opt;
        pick = $urandom_range(0, 99);
        act = $urandom_range(0, ACTION_COUNT - 1);
        lim = action_limit(3'(act));
        n = action_fields(3'(act));
        if (pick < 8) begin
            // action out of range, maybe followed by bytes that must be ignored
            queue_byte(8'($urandom_range(ACTION_COUNT, 255)), 1'b1);
            repeat ($urandom_range(0, 2)) queue_byte(8'($urandom), 1'b0);
        end else if (pick < 16 && lim != 255) begin
            queue_byte(8'(act), 1'b1);
            queue_byte(8'($urandom_range(lim + 1, 255)), 1'b0);
        end else if (pick < 22) begin
            // raw noise, occasionally with a start flag
            repeat ($urandom_range(1, 8))
                queue_byte(8'($urandom), ($urandom_range(0, 9) == 0));
        end else if (pick == 22 && n != 0) begin
            // one unterminated field running past the maximum frame length
            queue_byte(8'(act), 1'b1);
            queue_byte(8'($urandom_range(0, lim)), 1'b0);
            queue_byte(8'($urandom_range(254, 255)), 1'b0);
            repeat (MAX_FRAME_BYTES - HEADER_BYTES) queue_byte(printable(), 1'b0);
            queue_byte(8'($urandom), 1'b0);
            long_frames++;
        end else begin
            for (int k = 0; k < n; k++) begin
                len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                repeat (len) body.push_back(printable());
                body.push_back(CHAR_NUL);
            end
            sz = body.size();
            mut = $urandom_range(0, 9);
            case (mut)
                0: sz = (sz == 0) ? $urandom_range(1, 255) : $urandom_range(0, sz - 1);
                1: sz = sz + $urandom_range(1, 8);
                2: if (body.size() > 0) begin
                    body[$urandom_range(0, body.size() - 1)] = $urandom_range(0, 1) ?
                        8'($urandom_range(1, 8'h20)) : 8'($urandom_range(8'h7F, 8'hFF));
                end
                3: if (body.size() > 0) begin
                    // frame cut short, the next start drops it
                    repeat ($urandom_range(1, body.size())) void'(body.pop_back());
                end
                default: ;
            endcase
            opt = ($urandom_range(0, 3) == 0) ? 8'(lim) : 8'($urandom_range(0, lim));
            queue_byte(8'(act), 1'b1);
            queue_byte(opt, 1'b0);
            if (mut != 4) begin   // mut 4: header cut after the option byte
                queue_byte(8'(sz), 1'b0);
                foreach (body[k]) queue_byte(body[k], 1'b0);
            end
        end
    endfunction

    function automatic void add_random(int count);
        int target;
        target = pending_bytes.size() + count;
        while (pending_bytes.size() < target) add_frame();
    endfunction

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Write both registers (upper bits may carry junk) and read them back.
    task automatic set_config(input logic [APB_DW-1:0] lim, input logic [APB_DW-1:0] cnt);
        logic [APB_DW-1:0] rd;
        apb_access(1'b1, {REG_OPTION_LIMITS, 3'b000}, lim, rd);
        cfg_limits = lim[LIMITS_W-1:0];
        apb_access(1'b1, {REG_FIELD_COUNTS, 3'b000}, cnt, rd);
        cfg_counts = cnt[COUNTS_W-1:0];
        apb_access(1'b0, {REG_OPTION_LIMITS, 3'b000}, '0, rd);
        cmp_field("option_limits readback", 64'(cfg_limits), rd);
        apb_access(1'b0, {REG_FIELD_COUNTS, 3'b000}, '0, rd);
        cmp_field("field_counts readback", 64'(cfg_counts), rd);
        settings_used++;
    endtask

    // Wait until every queued byte went in and every result came out,
    // then give the two-stage pipeline time to settle.
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || i_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: input transactions and result-side stalls, changed on the
    // falling edge. An offered byte is held until a rising edge takes it.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !in_taken)) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                in_gap <= $urandom_range(0, 7);   // start a random-length idle burst
                i_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                i_valid <= 1'b1;
                i_data <= pending_bytes.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_stall <= 1'b1;
        end else if (i_rst_n && idle_on && $urandom_range(0, 7) == 0) begin
            out_gap <= $urandom_range(0, 7);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each accepted input, checks each accepted result.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                results_due.push_back(frame_step(i_data));
            if (o_valid && !i_stall) begin
                if (results_due.size() == 0) begin
                    if (mismatches < REPORT_CAP)
                        $error("result transaction with nothing expected: 0x%0h", o_data);
                    mismatches++;
                end else begin
                    next_result = results_due.pop_front();
                    cmp_field("payload_valid", next_result.payload_valid, o_data.payload_valid);
                    cmp_field("payload_byte", next_result.payload_byte, o_data.payload_byte);
                    cmp_field("field_number", next_result.field_number, o_data.field_number);
                    cmp_field("field_end", next_result.field_end, o_data.field_end);
                    cmp_field("verdict_valid", next_result.verdict_valid, o_data.verdict_valid);
                    cmp_field("status", next_result.status, o_data.status);
                    cmp_field("action_code", next_result.action_code, o_data.action_code);
                    cmp_field("option_code", next_result.option_code, o_data.option_code);
                    cmp_field("frame_length", next_result.frame_length, o_data.frame_length);
                    if (next_result.payload_valid)
                        payload_seen++;
                    if (next_result.verdict_valid)
                        verdict_seen[next_result.status]++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL frame_header_payload_validator_unit");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, registers still at reset (every action: limit 0, no fields).
        queue_byte(8'h41, 1'b0);                       // byte with no frame open
        queue_byte(8'h00, 1'b1);                       // action 0, option 0, size 0
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        wait_drained();

        // Action limits 7,3,10,0,255 and field counts 1,2,3,0,15.
        set_config(64'h00FF_000A_0307, 64'hF0321);
        queue_byte(8'hFF, 1'b1);                       // action out of range
        queue_byte(8'h01, 1'b1);                       // option above limit
        queue_byte(8'h04, 1'b0);
        queue_byte(8'h03, 1'b1);                       // no fields, nonzero size
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h05, 1'b0);
        queue_byte(8'h00, 1'b1);                       // last field ends the frame
        queue_byte(8'h07, 1'b0);
        queue_byte(8'h02, 1'b0);
        queue_byte(CHAR_LOW, 1'b0);
        queue_byte(CHAR_NUL, 1'b0);
        queue_byte(8'h00, 1'b1);                       // payload beyond declared size
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(CHAR_HIGH, 1'b0);
        queue_byte(CHAR_NUL, 1'b0);
        queue_byte(8'h01, 1'b1);                       // start inside an open frame
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h04, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h09, 1'b0);
        queue_byte(8'h20, 1'b0);                       // non-printable payload byte
        wait_drained();

        // Random phases over several register settings, extremes first.
        set_config('0, '0);
        add_random(120);
        wait_drained();

        set_config('1, '1);
        add_random(250);
        wait_drained();

        set_config({$urandom, $urandom}, {$urandom, $urandom});
        add_random(250);
        wait_drained();

        // Last phase: few fields per action, no idling on either side.
        set_config({$urandom, $urandom}, 64'($urandom) & 64'h33333);
        idle_on = 1'b0;
        add_random(300);
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Frames checked: %0d valid, %0d bad action, %0d bad option, %0d bad size,",
                 verdict_seen[ST_VALID], verdict_seen[ST_BAD_ACTION],
                 verdict_seen[ST_BAD_OPTION], verdict_seen[ST_BAD_SIZE]);
        $display("  %0d bad data; %0d payload bytes", verdict_seen[ST_BAD_DATA], payload_seen);
        $display("Register settings: %0d, over-length frames: %0d, cycles: %0d",
                 settings_used, long_frames, cycle_count);
        if (mismatches == 0) begin
            $display("PASS frame_header_payload_validator_unit");
        end else begin
            $display("FAIL frame_header_payload_validator_unit");
        end
        $finish;
    end

endmodule
